/* rtl/core/rtt_pkg.sv */
// Shared types and constants for the report throttle table.
`timescale 1ns / 1ps

package rtt_pkg;

    localparam int CODE_W = 16;
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] WINDOW_RESET = 32'd60000;

    typedef struct packed {
        logic valid;
        logic hit_found;
        logic hit_pass;
        logic free_found;
        logic victim_found;
    } probe_t;

    typedef struct packed {
        logic en;
        logic new_key;
    } wr_t;

endpackage

/* rtl/core/rtt_cell.sv */
// One table slot: holds a keyed entry and updates the lookup probe passing through.
`timescale 1ns / 1ps

module rtt_cell #(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rtt_pkg::CODE_W-1:0] code,
    input  logic [rtt_pkg::WORD_W-1:0] err,
    input  logic [rtt_pkg::WORD_W-1:0] tgt,
    input  logic [rtt_pkg::WORD_W-1:0] now,
    input  logic [rtt_pkg::WORD_W-1:0] window,
    input  rtt_pkg::probe_t            up_flags,
    input  logic [IDX_W-1:0]           up_hit_idx,
    input  logic [IDX_W-1:0]           up_free_idx,
    input  logic [IDX_W-1:0]           up_victim_idx,
    input  logic [rtt_pkg::WORD_W-1:0] up_victim_age,
    output rtt_pkg::probe_t            dn_flags,
    output logic [IDX_W-1:0]           dn_hit_idx,
    output logic [IDX_W-1:0]           dn_free_idx,
    output logic [IDX_W-1:0]           dn_victim_idx,
    output logic [rtt_pkg::WORD_W-1:0] dn_victim_age,
    input  rtt_pkg::wr_t               wr,
    input  logic [IDX_W-1:0]           wr_idx
);
    import rtt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              slot_valid_reg;
    logic [CODE_W-1:0] slot_code_reg;
    logic [WORD_W-1:0] slot_error_reg;
    logic [WORD_W-1:0] slot_target_reg;
    logic [WORD_W-1:0] slot_tick_reg;

    probe_t            dn_flags_reg,      dn_flags_next;
    logic [IDX_W-1:0]  dn_hit_idx_reg,    dn_hit_idx_next;
    logic [IDX_W-1:0]  dn_free_idx_reg,   dn_free_idx_next;
    logic [IDX_W-1:0]  dn_victim_idx_reg, dn_victim_idx_next;
    logic [WORD_W-1:0] dn_victim_age_reg, dn_victim_age_next;

    logic [WORD_W-1:0] age;
    logic              key_hit;
    logic              sel;

    assign age     = now - slot_tick_reg;
    assign key_hit = (slot_code_reg == code) && (slot_error_reg == err) &&
                     (slot_target_reg == tgt);
    assign sel     = wr.en && (wr_idx == MY_IDX);

    always_comb
    begin
        dn_flags_next      = up_flags;
        dn_hit_idx_next    = up_hit_idx;
        dn_free_idx_next   = up_free_idx;
        dn_victim_idx_next = up_victim_idx;
        dn_victim_age_next = up_victim_age;
        if (up_flags.valid)
        begin
            if (slot_valid_reg)
            begin
                if (!up_flags.hit_found && key_hit)
                begin
                    dn_flags_next.hit_found = 1'b1;
                    dn_flags_next.hit_pass  = (age >= window);
                    dn_hit_idx_next         = MY_IDX;
                end
                if (!up_flags.victim_found || (age > up_victim_age))
                begin
                    dn_flags_next.victim_found = 1'b1;
                    dn_victim_idx_next         = MY_IDX;
                    dn_victim_age_next         = age;
                end
            end
            else if (!up_flags.free_found)
            begin
                dn_flags_next.free_found = 1'b1;
                dn_free_idx_next         = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            dn_flags_reg   <= '0;
        end
        else
        begin
            dn_flags_reg <= dn_flags_next;
            if (sel && wr.new_key)
            begin
                slot_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dn_hit_idx_reg    <= dn_hit_idx_next;
        dn_free_idx_reg   <= dn_free_idx_next;
        dn_victim_idx_reg <= dn_victim_idx_next;
        dn_victim_age_reg <= dn_victim_age_next;
        if (sel)
        begin
            slot_tick_reg <= now;
            if (wr.new_key)
            begin
                slot_code_reg   <= code;
                slot_error_reg  <= err;
                slot_target_reg <= tgt;
            end
        end
    end

    assign dn_flags      = dn_flags_reg;
    assign dn_hit_idx    = dn_hit_idx_reg;
    assign dn_free_idx   = dn_free_idx_reg;
    assign dn_victim_idx = dn_victim_idx_reg;
    assign dn_victim_age = dn_victim_age_reg;

endmodule

/* rtl/core/report_throttle_table_unit.sv */
// Top level of the report throttle table: request capture, slot chain and result.
`timescale 1ns / 1ps

// Keyed rate limiter for problem reports. A request is taken when start is high
// and busy is low; its probe then walks the chain of TABLE_SLOTS slot cells, one
// cell per cycle, and the table update lands as it leaves the last cell. done
// pulses for one cycle with pass_report, both registered from the probe as it
// leaves the last cell, and busy drops in that same cycle, so the table works on
// one request at a time. The result cannot be held off: sample pass_report
// whenever done is high. Write window_ticks through cfg_we and cfg_wdata only
// while busy is low and no result is pending.
module report_throttle_table_unit #(
    parameter int TABLE_SLOTS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rtt_pkg::CODE_W-1:0] problem_code,
    input  logic [rtt_pkg::WORD_W-1:0] error_number,
    input  logic [rtt_pkg::WORD_W-1:0] target_id,
    input  logic [rtt_pkg::WORD_W-1:0] now_tick,
    input  logic                       cfg_we,
    input  logic [rtt_pkg::WORD_W-1:0] cfg_wdata,
    output logic                       done,
    output logic                       pass_report
);
    import rtt_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic              busy_reg,   busy_next;
    logic              done_reg,   done_next;
    logic              pass_reg,   pass_next;
    logic [WORD_W-1:0] window_reg;
    probe_t            head_reg,   head_next;
    logic [CODE_W-1:0] code_reg;
    logic [WORD_W-1:0] err_reg;
    logic [WORD_W-1:0] tgt_reg;
    logic [WORD_W-1:0] now_reg;

    probe_t            chain_flags      [TABLE_SLOTS+1];
    logic [IDX_W-1:0]  chain_hit_idx    [TABLE_SLOTS+1];
    logic [IDX_W-1:0]  chain_free_idx   [TABLE_SLOTS+1];
    logic [IDX_W-1:0]  chain_victim_idx [TABLE_SLOTS+1];
    logic [WORD_W-1:0] chain_victim_age [TABLE_SLOTS+1];
    logic [TABLE_SLOTS:0] probe_live;

    probe_t            tail;
    wr_t               wr;
    logic [IDX_W-1:0]  wr_idx;
    logic              accept;

    assign accept = start && !busy_reg;

    assign chain_flags[0]      = head_reg;
    assign chain_hit_idx[0]    = '0;
    assign chain_free_idx[0]   = '0;
    assign chain_victim_idx[0] = '0;
    assign chain_victim_age[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            rtt_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .code          (code_reg),
                .err           (err_reg),
                .tgt           (tgt_reg),
                .now           (now_reg),
                .window        (window_reg),
                .up_flags      (chain_flags[g]),
                .up_hit_idx    (chain_hit_idx[g]),
                .up_free_idx   (chain_free_idx[g]),
                .up_victim_idx (chain_victim_idx[g]),
                .up_victim_age (chain_victim_age[g]),
                .dn_flags      (chain_flags[g+1]),
                .dn_hit_idx    (chain_hit_idx[g+1]),
                .dn_free_idx   (chain_free_idx[g+1]),
                .dn_victim_idx (chain_victim_idx[g+1]),
                .dn_victim_age (chain_victim_age[g+1]),
                .wr            (wr),
                .wr_idx        (wr_idx)
            );
        end
        for (g = 0; g <= TABLE_SLOTS; g++)
        begin : g_live
            assign probe_live[g] = chain_flags[g].valid;
        end
    endgenerate

    assign tail = chain_flags[TABLE_SLOTS];

    always_comb
    begin
        wr.en      = tail.valid && (!tail.hit_found || tail.hit_pass);
        wr.new_key = !tail.hit_found;
        if (tail.hit_found)
        begin
            wr_idx = chain_hit_idx[TABLE_SLOTS];
        end
        else if (tail.free_found)
        begin
            wr_idx = chain_free_idx[TABLE_SLOTS];
        end
        else
        begin
            wr_idx = chain_victim_idx[TABLE_SLOTS];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end
        done_next       = tail.valid;
        pass_next       = !tail.hit_found || tail.hit_pass;
        head_next       = '0;
        head_next.valid = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            head_reg   <= '0;
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            head_reg <= head_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        if (accept)
        begin
            code_reg <= problem_code;
            err_reg  <= error_number;
            tgt_reg  <= target_id;
            now_reg  <= now_tick;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign pass_report = pass_reg;

    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_live))
        else $error("more than one probe in the slot chain");

    a_probe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (probe_live != '0) |-> busy_reg)
        else $error("probe in flight while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && head_reg.valid)
        else $error("accepted request did not enter the chain");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(tail.valid))
        else $error("result strobe without a finished probe");

    a_victim_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.valid && !tail.free_found) |-> tail.victim_found)
        else $error("full table without an eviction candidate");

endmodule
